// ===== hw/rtl/mxe_pkg.sv =====
// Shared constants, types and helper functions for the Taylor matrix exponential block.
`timescale 1ns / 1ps
`default_nettype none
package mxe_pkg;

    // Geometry of the stored matrices.
    localparam int MAX_DIM = 8;
    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int IDX_W   = $clog2(CELLS);
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int NUM_W   = DIM_W + 1;
    localparam int CNT_W   = 7;

    // Element and accumulator widths.
    localparam int ELEM_W  = 32;
    localparam int OPB_W   = 33;
    localparam int PROD_W  = ELEM_W + OPB_W;
    localparam int SUM_W   = PROD_W + DIM_W;
    localparam int TS_W    = 24;

    // Saturation limits and fixed constants.
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
    localparam logic signed [ELEM_W-1:0] ONE_Q16 = 32'sd65536;
    // ceil(2^34 / 3): exact floor division by three for values below 2^33.
    localparam logic [32:0] DIV3_M = 33'd5726623062;
    localparam int DIV3_SH = 34;

    // Configuration register indexes.
    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_TS    = 2'd1;
    localparam logic [1:0] REG_ORDER = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_DIV,
        ST_ADD,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    typedef enum logic [1:0] {
        PH_SCALE,
        PH_SQUARE,
        PH_CUBE
    } t_phase;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic issue;
        logic clear;
    } t_mac_ctl;

    // Saturate a wide value to a 32-bit word; the top bit flags saturation.
    function automatic logic [ELEM_W:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic [ELEM_W:0] res;
        if (v > SAT_HI) begin
            res = {1'b1, SAT_HI[ELEM_W-1:0]};
        end else if (v < SAT_LO) begin
            res = {1'b1, SAT_LO[ELEM_W-1:0]};
        end else begin
            res = {1'b0, v[ELEM_W-1:0]};
        end
        return res;
    endfunction

    // Row-major position of a cell in an n-by-n matrix.
    function automatic logic [IDX_W-1:0] cell_idx(input logic [DIM_W-1:0] row,
                                                  input logic [DIM_W-1:0] col,
                                                  input logic [NUM_W-1:0] n);
        logic [CNT_W-1:0] t;
        t = CNT_W'(row) * CNT_W'(n) + CNT_W'(col);
        return t[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/matrix_exponential_taylor3_core.sv =====
// Top level: loads F, forms Phi = I + A + A^2/2 + A^3/6 (A = F*Ts) up to the set order, and streams Phi out.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-------------------------------------
//  in       | sink      | i_in_valid / o_in_stall      | i_matrix_element
//  out      | source    | o_out_valid / i_out_stall    | o_phi_element, o_row_index,
//           |           |                              | o_col_index, o_last_element,
//           |           |                              | o_order_invalid, o_overflowed
//  config   | APB slave | psel / penable / pready      | paddr, pwdata, prdata
//
// Loading accepts one item per cycle. After the last item the sequencer runs over the N*N cells
// with one multiplier and registered RAM reads. In the scaling, square and cube passes a cell
// runs the product loop, its drain, rounding and the add; the cube pass adds a division step.
// Each cell is read, then emitted; the input is accepted again once the last cell is queued.
// Reset is synchronous and active low and clears control state only; the RAMs are not cleared.
// A stalled output holds its item; the sequencer waits on it during the emit pass.
`timescale 1ns / 1ps
`default_nettype none
module matrix_exponential_taylor3_core
    import mxe_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    // Input items
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire signed [31:0] i_matrix_element,
    // Result items
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic signed [31:0] o_phi_element,
    output logic [2:0]        o_row_index,
    output logic [2:0]        o_col_index,
    output logic              o_last_element,
    output logic              o_order_invalid,
    output logic              o_overflowed,
    // Configuration
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [3:0]         paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Configuration registers.
    logic [3:0]      r_size;
    logic [TS_W-1:0] r_ts;
    logic [2:0]      r_order_cfg;

    // Sequencer state.
    t_state              r_state, n_state;
    t_phase              r_phase;
    logic [CNT_W-1:0]    r_lc;
    logic [NUM_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_cells;
    logic [2:0]          r_order;
    logic                r_inv;
    logic                r_sticky;
    logic [DIM_W-1:0]    r_i, r_j, r_k;
    logic [IDX_W-1:0]    r_e;

    // Datapath registers.
    logic signed [ELEM_W-1:0] r_val;
    logic [65:0]              r_qprod;

    // Memories and their registered read data.
    logic signed [ELEM_W-1:0] r_f_mem   [CELLS];
    logic signed [ELEM_W-1:0] r_a_mem   [CELLS];
    logic signed [ELEM_W-1:0] r_p_mem   [CELLS];
    logic [ELEM_W:0]          r_acc_mem [CELLS];
    logic signed [ELEM_W-1:0] r_f_rd, r_a_rd_a, r_a_rd_b, r_p_rd;
    logic [ELEM_W:0]          r_acc_rd;

    // Output register.
    logic               r_o_valid;
    logic signed [31:0] r_o_phi;
    logic [2:0]         r_o_row, r_o_col;
    logic               r_o_last, r_o_inv, r_o_ovf;

    // Combinational signals.
    logic               w_cfg_wr;
    logic               w_accept;
    logic [NUM_W-1:0]   w_n_live;
    logic [CNT_W-1:0]   w_cells_live;
    logic [CNT_W-1:0]   w_lc_inc;
    logic               w_done;
    logic               w_inv_live;
    logic [DIM_W-1:0]   w_kmax;
    logic               w_last_e;
    logic               w_out_free;
    logic               w_more_phase;
    t_phase             w_next_phase;
    logic [IDX_W-1:0]   w_row_k, w_k_col;
    t_mac_ctl           w_mac_ctl;
    logic signed [ELEM_W-1:0] w_op_a;
    logic signed [OPB_W-1:0]  w_op_b;
    logic signed [SUM_W-1:0]  w_sum;
    logic               w_mac_busy;
    logic signed [SUM_W-1:0]  w_round;
    logic [ELEM_W:0]    w_round_sat;
    logic signed [ELEM_W-1:0] w_ident;
    logic signed [32:0] w_half_in;
    logic [32:0]        w_div_u;
    logic signed [32:0] w_term;
    logic signed [ELEM_W-1:0] w_acc_old;
    logic               w_ovf_old;
    logic [ELEM_W:0]    w_add_sat;

    // APB configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= 4'd3;
            r_ts        <= 24'd1677722;
            r_order_cfg <= 3'd2;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_SIZE:  r_size      <= pwdata[3:0];
                REG_TS:    r_ts        <= pwdata[TS_W-1:0];
                REG_ORDER: r_order_cfg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SIZE:  prdata = {28'd0, r_size};
            REG_TS:    prdata = {8'd0, r_ts};
            REG_ORDER: prdata = {29'd0, r_order_cfg};
            default:   prdata = '0;
        endcase
    end

    // Load bookkeeping with the size clamped to 1..MAX_DIM.
    always_comb begin
        if (r_size == 4'd0) begin
            w_n_live = NUM_W'(1);
        end else if (r_size > 4'(MAX_DIM)) begin
            w_n_live = NUM_W'(MAX_DIM);
        end else begin
            w_n_live = NUM_W'(r_size);
        end
    end
    assign w_cells_live = CNT_W'(w_n_live) * CNT_W'(w_n_live);
    assign w_lc_inc     = r_lc + CNT_W'(1);
    assign w_done       = (w_lc_inc >= w_cells_live);
    assign w_inv_live   = (r_order_cfg < 3'd1) || (r_order_cfg > 3'd3);
    assign o_in_stall   = (r_state != ST_LOAD);
    assign w_accept     = i_in_valid & ~o_in_stall;

    // Loop bounds and phase order.
    assign w_kmax     = (r_phase == PH_SCALE) ? '0 : DIM_W'(r_n - NUM_W'(1));
    assign w_last_e   = (CNT_W'(r_e) == r_cells - CNT_W'(1));
    assign w_out_free = ~r_o_valid | ~i_out_stall;

    always_comb begin
        w_more_phase = 1'b0;
        w_next_phase = r_phase;
        case (r_phase)
            PH_SCALE: begin
                w_more_phase = (r_order >= 3'd2);
                w_next_phase = PH_SQUARE;
            end
            PH_SQUARE: begin
                w_more_phase = (r_order == 3'd3);
                w_next_phase = PH_CUBE;
            end
            default: begin
                w_more_phase = 1'b0;
                w_next_phase = r_phase;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && w_done) begin
                    n_state = w_inv_live ? ST_EMIT_RD : ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_k == w_kmax) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_mac_busy) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = (r_phase == PH_CUBE) ? ST_DIV : ST_ADD;
            end
            ST_DIV: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                if (w_last_e && !w_more_phase) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_MAC;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (w_out_free) begin
                    n_state = w_last_e ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Counters, phase and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SCALE;
            r_lc     <= '0;
            r_n      <= NUM_W'(1);
            r_cells  <= CNT_W'(1);
            r_order  <= '0;
            r_inv    <= 1'b0;
            r_sticky <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_e      <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (w_done) begin
                            r_lc     <= '0;
                            r_n      <= w_n_live;
                            r_cells  <= w_cells_live;
                            r_order  <= r_order_cfg;
                            r_inv    <= w_inv_live;
                            r_sticky <= 1'b0;
                            r_phase  <= PH_SCALE;
                            r_i      <= '0;
                            r_j      <= '0;
                            r_k      <= '0;
                            r_e      <= '0;
                        end else begin
                            r_lc <= w_lc_inc;
                        end
                    end
                end
                ST_MAC: begin
                    r_k <= (r_k == w_kmax) ? '0 : r_k + DIM_W'(1);
                end
                ST_ROUND: begin
                    r_sticky <= r_sticky | w_round_sat[ELEM_W];
                end
                ST_ADD: begin
                    if (w_last_e) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_e <= '0;
                        if (w_more_phase) begin
                            r_phase <= w_next_phase;
                        end
                    end else begin
                        r_e <= r_e + IDX_W'(1);
                        if (NUM_W'(r_j) == r_n - NUM_W'(1)) begin
                            r_j <= '0;
                            r_i <= r_i + DIM_W'(1);
                        end else begin
                            r_j <= r_j + DIM_W'(1);
                        end
                    end
                end
                ST_EMIT_WR: begin
                    if (w_out_free) begin
                        if (w_last_e) begin
                            r_i <= '0;
                            r_j <= '0;
                            r_e <= '0;
                        end else begin
                            r_e <= r_e + IDX_W'(1);
                            if (NUM_W'(r_j) == r_n - NUM_W'(1)) begin
                                r_j <= '0;
                                r_i <= r_i + DIM_W'(1);
                            end else begin
                                r_j <= r_j + DIM_W'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Operand addresses for the product loop.
    assign w_row_k = cell_idx(r_i, r_k, r_n);
    assign w_k_col = cell_idx(r_k, r_j, r_n);

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (w_accept && !r_lc[CNT_W-1]) begin
            r_f_mem[r_lc[IDX_W-1:0]] <= i_matrix_element;
        end
        r_f_rd <= r_f_mem[r_e];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND && r_phase == PH_SCALE) begin
            r_a_mem[r_e] <= w_round_sat[ELEM_W-1:0];
        end
        r_a_rd_a <= r_a_mem[w_row_k];
        r_a_rd_b <= r_a_mem[w_k_col];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND && r_phase == PH_SQUARE) begin
            r_p_mem[r_e] <= w_round_sat[ELEM_W-1:0];
        end
        r_p_rd <= r_p_mem[w_row_k];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADD) begin
            r_acc_mem[r_e] <= {w_ovf_old | w_add_sat[ELEM_W], w_add_sat[ELEM_W-1:0]};
        end
        r_acc_rd <= r_acc_mem[r_e];
    end

    // Multiply-accumulate unit.
    assign w_mac_ctl = '{issue: (r_state == ST_MAC),
                         clear: (r_state == ST_MAC) && (r_k == '0)};

    always_comb begin
        case (r_phase)
            PH_SCALE: begin
                w_op_a = r_f_rd;
                w_op_b = OPB_W'({1'b0, r_ts});
            end
            PH_SQUARE: begin
                w_op_a = r_a_rd_a;
                w_op_b = OPB_W'(r_a_rd_b);
            end
            default: begin
                w_op_a = r_p_rd;
                w_op_b = OPB_W'(r_a_rd_b);
            end
        endcase
    end

    mxe_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .o_sum   (w_sum),
        .o_busy  (w_mac_busy)
    );

    // Round half up to Q16.16 and saturate.
    always_comb begin
        if (r_phase == PH_SCALE) begin
            w_round = (w_sum + SUM_W'(64'sd8388608)) >>> 24;
        end else begin
            w_round = (w_sum + SUM_W'(64'sd32768)) >>> 16;
        end
    end
    assign w_round_sat = sat_word(w_round);

    // Division of the cube term by six: halve, then divide by three with a reciprocal.
    assign w_half_in = (33'(r_val) + 33'sd3) >>> 1;
    assign w_div_u   = 33'(w_half_in + 33'sd3221225472);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND) begin
            r_val <= w_round_sat[ELEM_W-1:0];
        end
        if (r_state == ST_DIV) begin
            r_qprod <= 66'(w_div_u) * 66'(DIV3_M);
        end
    end

    // Series term for this phase, added to the running sum with saturation.
    assign w_ident = (r_i == r_j) ? ONE_Q16 : '0;

    always_comb begin
        case (r_phase)
            PH_SCALE: begin
                w_term    = 33'(r_val);
                w_acc_old = w_ident;
                w_ovf_old = 1'b0;
            end
            PH_SQUARE: begin
                w_term    = (33'(r_val) + 33'sd1) >>> 1;
                w_acc_old = r_acc_rd[ELEM_W-1:0];
                w_ovf_old = r_acc_rd[ELEM_W];
            end
            default: begin
                w_term    = 33'({1'b0, r_qprod[65:DIV3_SH]}) - 33'sd1073741824;
                w_acc_old = r_acc_rd[ELEM_W-1:0];
                w_ovf_old = r_acc_rd[ELEM_W];
            end
        endcase
    end
    assign w_add_sat = sat_word(SUM_W'(w_acc_old) + SUM_W'(w_term));

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_EMIT_WR && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT_WR && w_out_free) begin
            r_o_phi  <= r_inv ? w_ident : r_acc_rd[ELEM_W-1:0];
            r_o_row  <= r_i;
            r_o_col  <= r_j;
            r_o_last <= w_last_e;
            r_o_inv  <= r_inv;
            r_o_ovf  <= ~r_inv & (r_sticky | r_acc_rd[ELEM_W]);
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_phi_element   = r_o_phi;
    assign o_row_index     = r_o_row;
    assign o_col_index     = r_o_col;
    assign o_last_element  = r_o_last;
    assign o_order_invalid = r_o_inv;
    assign o_overflowed    = r_o_ovf;

`ifndef SYNTHESIS
    // Rounding only starts once every product of the cell has been summed.
    a_round_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> !w_mac_busy)
        else $error("rounding started with products in flight");
    // The inner index never runs past the product length.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_k <= w_kmax))
        else $error("inner index out of range");
    // Completing a load restarts the count and the overflow flag.
    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_done) |=> (r_lc == '0) && !r_sticky)
        else $error("load count or overflow flag not restarted");
    // An invalid order goes straight to emitting the identity.
    a_inv_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_done && w_inv_live) |=> (r_state == ST_EMIT_RD))
        else $error("invalid order did not skip the series");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/mxe_mac.sv =====
// Pipelined multiply-accumulate unit shared by the scaling pass and both matrix products.
`timescale 1ns / 1ps
`default_nettype none
module mxe_mac
    import mxe_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire t_mac_ctl            i_ctl,
    input  wire signed [ELEM_W-1:0]  i_op_a,
    input  wire signed [OPB_W-1:0]   i_op_b,
    output logic signed [SUM_W-1:0]  o_sum,
    output logic                     o_busy
);

    logic                     r_v1;
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;

    // Operands arrive in the cycle after the read is issued; the product is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= PROD_W'(i_op_a) * PROD_W'(i_op_b);
        end
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (r_v2) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
    end

    assign o_sum  = r_sum;
    assign o_busy = r_v1 | r_v2;

`ifndef SYNTHESIS
    // A clear never collides with a product still in flight.
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |-> !r_v2)
        else $error("accumulator cleared while a product is pending");
    // Every accumulated product stems from an issue that was carried through r_v1 into r_v2.
    a_v2_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(i_ctl.issue, 2))
        else $error("product valid without a matching issue");
    a_v1_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(i_ctl.issue))
        else $error("operand valid without a matching issue");
`endif

endmodule
`default_nettype wire
